[sv/cau_pkg.sv]
package cau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_CONJ = 3'd4,
    CMD_MAG  = 3'd5
  } cmd_t;

  localparam int DW = 32;

  // item as it travels from the front part to the back part
  typedef struct packed {
    logic [2:0]           cmd;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } op_t;

  // result item
  typedef struct packed {
    logic [DW-1:0] re;
    logic [DW-1:0] im;
    logic          dbz;
    logic          sat;
  } res_t;

  // clip a sign/magnitude value to the signed 32-bit range
  function automatic logic [DW:0] clip_sm(input logic neg, input logic [64:0] mag);
    logic [DW:0] r;
    if (neg) begin
      if (mag > 65'h80000000) r = {1'b1, 32'h80000000};
      else r = {1'b0, 32'(-mag[DW-1:0])};
    end else begin
      if (mag > 65'h7fffffff) r = {1'b1, 32'h7fffffff};
      else r = {1'b0, mag[DW-1:0]};
    end
    return r;
  endfunction

endpackage

[sv/complex_arith_unit.sv]
// Pipeline: one product stage, 33+FRAC_BITS quotient stages and two more stages lie
// between the input queue and the head; divide and root stages are unrolled pipelines.
// Throughput: one item per cycle unless a waiting result freezes the pipeline.
// A waiting result freezes the pipeline; the 4-entry input queue then fills and full rises.
// Reset (rst_n low, synchronous) empties the input queue and the pipeline.
module complex_arith_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_command,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] out_res_re,
  output logic signed [31:0] out_res_im,
  output logic        out_divide_by_zero,
  output logic        out_saturated
);
  import cau_pkg::*;

  op_t  in_op, q_op;
  res_t res;
  logic q_valid, q_take, o_valid;

  assign in_op = '{cmd: in_command, a_re: in_a_re, a_im: in_a_im,
                   b_re: in_b_re, b_im: in_b_im};

  cau_front u_front (
    .clk, .rst_n, .push, .full, .in_op, .q_valid, .q_op, .q_take
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_op, .q_take,
    .out_valid(o_valid), .out_res(res), .out_take(pop)
  );

  assign empty              = !o_valid;
  assign out_res_re         = res.re;
  assign out_res_im         = res.im;
  assign out_divide_by_zero = res.dbz;
  assign out_saturated      = res.sat;
endmodule

[sv/cau_front.sv]
// Front part: accept items into a short queue that feeds the back part.
module cau_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  cau_pkg::op_t  in_op,
  output logic          q_valid,
  output cau_pkg::op_t  q_op,
  input  logic          q_take
);
  import cau_pkg::*;

  localparam int DEPTH = 4;

  op_t        mem_r [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       wr, rd;

  assign full    = (cnt_r == 3'(DEPTH));
  assign q_valid = (cnt_r != 3'd0);
  assign q_op    = mem_r[rp_r];
  assign wr      = push && !full;
  assign rd      = q_take && q_valid;

  // store accepted items
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= in_op;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'(DEPTH))
    else $error("queue count over depth");
  a_full: assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr)
    else $error("write while full");
  a_emp: assert property (@(posedge clk) disable iff (!rst_n)
      (!q_valid && !wr) |=> !q_valid)
    else $error("queue went valid without write");
endmodule

[sv/cau_back.sv]
// Back part: pipelined datapath with iterative-stage divider and root.
// Stage 0: products. Stages 1..: one quotient / root bit per stage.
// The last stage holds the result at the output; a waiting result freezes
// the whole pipeline, and with it the intake from the front queue.
module cau_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  cau_pkg::op_t  q_op,
  output logic          q_take,
  output logic          out_valid,
  output cau_pkg::res_t out_res,
  input  logic          out_take
);
  import cau_pkg::*;

  // quotient width: 32 integer bits plus FRAC_BITS+1 fraction bits
  localparam int QB   = 33 + FRAC_BITS;   // quotient bits computed: up to 2^(33+FRAC_BITS) range
  localparam int RB   = 32;               // root bits
  localparam int NS   = (QB > RB) ? QB : RB;
  localparam int LAT  = NS + 3;
  localparam int RW   = 66 + FRAC_BITS;   // dividend scaled by 2^(FRAC_BITS+1)

  // ------------ pipeline state per stage ------------
  typedef struct packed {
    logic        v;
    logic [2:0]  cmd;
    logic        dbz;
    logic        nre, nim;
    logic [64:0] mre, mim;     // magnitudes / direct values
    logic [64:0] den;
    logic [RW-1:0] rre, rim;   // division remainders
    logic [QB-1:0] qre, qim;   // quotients
    logic [65:0] sx;           // sqrt operand
    logic [65:0] srem;
    logic [33:0] sres;
  } st_t;

  st_t s_r [LAT];

  logic adv;

  // advance when the last stage is empty or its result is taken
  assign adv    = !s_r[LAT-1].v || out_take;
  assign q_take = adv;

  // ---------- stage 0: products ----------
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [65:0] sa, sb;
  st_t st0;
  always_comb begin
    logic signed [32:0] d;
    logic [64:0] den;
    p_rr = q_op.a_re * q_op.b_re;
    p_ii = q_op.a_im * q_op.b_im;
    p_ri = q_op.a_re * q_op.b_im;
    p_ir = q_op.a_im * q_op.b_re;
    st0 = '0;
    st0.v = q_valid && q_take;
    st0.cmd = q_op.cmd;
    sa = '0; sb = '0; d = '0; den = '0;
    unique case (q_op.cmd)
      CMD_ADD: begin
        sa = 66'(q_op.a_re) + 66'(q_op.b_re);
        sb = 66'(q_op.a_im) + 66'(q_op.b_im);
      end
      CMD_SUB: begin
        sa = 66'(q_op.a_re) - 66'(q_op.b_re);
        sb = 66'(q_op.a_im) - 66'(q_op.b_im);
      end
      CMD_MUL: begin
        sa = 66'(p_rr) - 66'(p_ii);
        sb = 66'(p_ir) + 66'(p_ri);
      end
      CMD_DIV: begin
        sa = 66'(p_rr) + 66'(p_ii);
        sb = 66'(p_ir) - 66'(p_ri);
        den = 65'($unsigned(64'(q_op.b_re * q_op.b_re)))
            + 65'($unsigned(64'(q_op.b_im * q_op.b_im)));
      end
      CMD_CONJ: begin
        sa = 66'(q_op.a_re);
        d  = -33'(q_op.a_im);
        sb = 66'(d);
      end
      CMD_MAG: begin
        st0.sx = 66'($unsigned(64'(q_op.a_re * q_op.a_re)))
               + 66'($unsigned(64'(q_op.a_im * q_op.a_im)));
      end
      default: ;
    endcase
    st0.nre = sa[65];
    st0.nim = sb[65];
    st0.mre = sa[65] ? 65'(-sa) : 65'(sa);
    st0.mim = sb[65] ? 65'(-sb) : 65'(sb);
    st0.den = den;
    st0.dbz = (q_op.cmd == CMD_DIV) && (den == '0);
    st0.srem = st0.sx;
  end

  // ---------- stage step: one quotient bit and, in the first RB steps, one root bit ----------
  function automatic st_t step(input st_t s, input int k);
    st_t o;
    logic [65:0] t;
    logic [RW-1:0] tr, ti;
    logic [131:0] dsh;
    int sh;
    o = s;
    sh = QB - 1 - k;
    // restoring division bit: compare rem against den << sh
    if (k < QB) begin
      dsh = 132'(s.den) << sh;
      tr = s.rre; ti = s.rim;
      if (s.den != '0 && 132'(tr) >= dsh) begin
        o.rre = tr - RW'(dsh); o.qre[sh] = 1'b1;
      end
      if (s.den != '0 && 132'(ti) >= dsh) begin
        o.rim = ti - RW'(dsh); o.qim[sh] = 1'b1;
      end
    end
    // root bit, MSB first on 66-bit operand
    if (k < RB) begin
      t = 66'(({34'd0, s.sres} << (RB - k)) | (66'd1 << (2*(RB - 1 - k))));
      if (s.srem >= t) begin
        o.srem = s.srem - t;
        o.sres = s.sres | (34'd1 << (RB - 1 - k));
      end
    end
    return o;
  endfunction

  // ---------- pipeline ----------
  st_t ent;
  always_comb begin
    ent = st0;
    // division works on mag << (FRAC_BITS + 1); the extra bit drives rounding
    ent.rre = RW'(st0.mre) << (FRAC_BITS + 1);
    ent.rim = RW'(st0.mim) << (FRAC_BITS + 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) s_r[i].v <= 1'b0;
    end else if (adv) begin
      s_r[0] <= ent;
      for (int i = 1; i < NS + 1; i++) s_r[i] <= step(s_r[i-1], i - 1);
      for (int i = NS + 1; i < LAT; i++) s_r[i] <= s_r[i-1];
    end
  end

  // ---------- finish: rounding and clipping ----------
  res_t fin;
  always_comb begin
    st_t s;
    logic [64:0] mr, mi;
    logic [FRAC_BITS:0] halfv;
    logic [DW:0] cr, ci;
    logic [65:0] rnd;
    s = s_r[LAT-1];
    halfv = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
    mr = s.mre; mi = s.mim;
    cr = '0; ci = '0; rnd = '0;
    fin = '0;
    unique case (s.cmd) inside
      CMD_ADD, CMD_SUB, CMD_CONJ: begin
        cr = clip_sm(s.nre, mr); ci = clip_sm(s.nim, mi);
        fin.re = cr[DW-1:0]; fin.im = ci[DW-1:0]; fin.sat = cr[DW] | ci[DW];
      end
      CMD_MUL: begin
        cr = clip_sm(s.nre, 65'((66'(mr) + 66'(halfv)) >> FRAC_BITS));
        ci = clip_sm(s.nim, 65'((66'(mi) + 66'(halfv)) >> FRAC_BITS));
        fin.re = cr[DW-1:0]; fin.im = ci[DW-1:0]; fin.sat = cr[DW] | ci[DW];
      end
      CMD_DIV: begin
        if (s.dbz) begin
          fin.dbz = 1'b1;
        end else begin
          // quotient holds integer bits then FRAC_BITS+1 fraction bits
          rnd = (66'(s.qre) + 66'd1) >> 1;
          cr = clip_sm(s.nre, 65'(rnd));
          rnd = (66'(s.qim) + 66'd1) >> 1;
          ci = clip_sm(s.nim, 65'(rnd));
          fin.re = cr[DW-1:0]; fin.im = ci[DW-1:0]; fin.sat = cr[DW] | ci[DW];
        end
      end
      CMD_MAG: begin
        rnd = (s.srem > 66'(s.sres)) ? 66'(s.sres) + 66'd1 : 66'(s.sres);
        cr = clip_sm(1'b0, 65'(rnd));
        fin.re = cr[DW-1:0]; fin.sat = cr[DW];
      end
      default: ;
    endcase
  end

  // ---------- output: last stage holds the waiting result ----------
  assign out_valid = s_r[LAT-1].v;
  assign out_res   = fin;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && !out_take) |=> (out_valid && $stable(out_res)))
    else $error("waiting result changed");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_res.dbz) |-> (out_res.re == '0 && out_res.im == '0))
    else $error("divide by zero result not zero");
  a_dbz: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_res.dbz) |-> !out_res.sat)
    else $error("divide by zero flagged saturated");
endmodule

[test/complex_arith_unit_tb.sv]
`timescale 1ns / 1ps

module complex_arith_unit_tb;
  import cau_pkg::*;

  localparam int FRAC = 16;
  localparam int N_RANDOM = 1000;
  localparam int CALM_FROM = 900;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
  } operands_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        dbz;
    logic        sat;
  } cplx_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [2:0] in_command = '0;
  logic signed [31:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic signed [31:0] out_res_re, out_res_im;
  logic out_divide_by_zero, out_saturated;

  cplx_res_t offered_res;
  cplx_res_t pending_res[$];
  int errors = 0;
  bit calm = 1'b0;

  complex_arith_unit uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_command(in_command), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im), .empty(empty), .pop(pop),
    .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_divide_by_zero(out_divide_by_zero), .out_saturated(out_saturated)
  );

  always #1 clk = ~clk;

  // clip a sign/magnitude value into 32 signed bits
  function automatic logic [31:0] clamp(input bit neg, input bit [63:0] mag, inout bit sat);
    if (neg) begin
      if (mag > 64'h80000000) begin
        sat = 1'b1;
        return 32'h80000000;
      end
      return 32'(64'd0 - mag);
    end
    if (mag > 64'h7fffffff) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    return mag[31:0];
  endfunction

  function automatic logic [31:0] clamp_s(input longint v, inout bit sat);
    if (v < 0) return clamp(1'b1, 64'd0 - 64'(v), sat);
    return clamp(1'b0, 64'(v), sat);
  endfunction

  // wrapped 64-bit sum whose true value lies in (-2^63, 2^63]
  function automatic void split_sm(input bit [63:0] u, output bit neg, output bit [63:0] mag);
    neg = u[63] && (u != 64'h8000000000000000);
    mag = neg ? 64'd0 - u : u;
  endfunction

  function automatic bit [63:0] root_rounded(input bit [63:0] x);
    bit [63:0] rem, res, b;
    rem = x;
    res = 0;
    b = 64'h4000000000000000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    if (rem > res) res = res + 1;
    return res;
  endfunction

  // round(mag * 2^FRAC / den), long division one bit at a time
  function automatic bit [63:0] quot_rounded(input bit [63:0] mag, input bit [63:0] den);
    bit [63:0] q, r;
    q = mag / den;
    r = mag % den;
    if (q > (64'd1 << (32 - FRAC))) return 64'd1 << 40;
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    if ((r << 1) >= den) q = q + 1;
    return q;
  endfunction

  function automatic cplx_res_t calc_result(input operands_t op);
    cplx_res_t o;
    longint ar, ai, br, bi;
    bit [63:0] half, mag, den;
    bit neg, sat;
    ar = op.ar;
    ai = op.ai;
    br = op.br;
    bi = op.bi;
    half = 64'd1 << (FRAC - 1);
    sat = 1'b0;
    o = '{re: '0, im: '0, dbz: 1'b0, sat: 1'b0};
    case (op.cmd)
      CMD_ADD: begin
        o.re = clamp_s(ar + br, sat);
        o.im = clamp_s(ai + bi, sat);
      end
      CMD_SUB: begin
        o.re = clamp_s(ar - br, sat);
        o.im = clamp_s(ai - bi, sat);
      end
      CMD_MUL: begin
        split_sm(64'(ar * br) - 64'(ai * bi), neg, mag);
        o.re = clamp(neg, (mag + half) >> FRAC, sat);
        split_sm(64'(ai * br) + 64'(ar * bi), neg, mag);
        o.im = clamp(neg, (mag + half) >> FRAC, sat);
      end
      CMD_DIV: begin
        den = 64'(br * br) + 64'(bi * bi);
        if (den == 0) begin
          o.dbz = 1'b1;
        end else begin
          split_sm(64'(ar * br) + 64'(ai * bi), neg, mag);
          o.re = clamp(neg, quot_rounded(mag, den), sat);
          split_sm(64'(br * ai) - 64'(bi * ar), neg, mag);
          o.im = clamp(neg, quot_rounded(mag, den), sat);
        end
      end
      CMD_CONJ: begin
        o.re = clamp_s(ar, sat);
        o.im = clamp_s(-ai, sat);
      end
      CMD_MAG: begin
        o.re = clamp(1'b0, root_rounded(64'(ar * ar) + 64'(ai * ai)), sat);
      end
      default: ;
    endcase
    o.sat = sat;
    return o;
  endfunction

  // record accepted items and check accepted results against the oldest expectation
  always @(posedge clk) begin
    cplx_res_t e;
    if (rst_n) begin
      if (push && !full) pending_res.push_back(offered_res);
      if (pop && !empty) begin
        if (pending_res.size() == 0) begin
          $error("result with nothing pending: re=%h im=%h", out_res_re, out_res_im);
          errors++;
        end else begin
          e = pending_res.pop_front();
          if (out_res_re !== e.re) begin
            $error("res_re expected %h actual %h", e.re, out_res_re);
            errors++;
          end
          if (out_res_im !== e.im) begin
            $error("res_im expected %h actual %h", e.im, out_res_im);
            errors++;
          end
          if (out_divide_by_zero !== e.dbz) begin
            $error("divide_by_zero expected %b actual %b", e.dbz, out_divide_by_zero);
            errors++;
          end
          if (out_saturated !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, out_saturated);
            errors++;
          end
        end
      end
    end
  end

  // offer one item and hold it until accepted
  task automatic send_item(input operands_t op, input cplx_res_t res);
    in_command <= op.cmd;
    in_a_re <= op.ar;
    in_a_im <= op.ai;
    in_b_re <= op.br;
    in_b_im <= op.bi;
    offered_res <= res;
    push <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  // drop push for a random burst now and then
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      2: case ($urandom_range(0, 4))
           0: return 32'h80000000;
           1: return 32'h7fffffff;
           2: return 32'hffffffff;
           3: return 32'd1;
           default: return 32'd0;
         endcase
      3: return 32'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
      default: return 32'd0;
    endcase
  endfunction

  function automatic operands_t pick_operands();
    operands_t op;
    if ($urandom_range(0, 15) == 0) op.cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
    else op.cmd = 3'($urandom_range(0, 5));
    op.ar = pick_value();
    op.ai = pick_value();
    op.br = pick_value();
    op.bi = pick_value();
    return op;
  endfunction

  // receiver: random stall bursts plus one long hold-off to fill the block
  initial begin
    int stall;
    int cyc;
    stall = 0;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 300) stall = 400;
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(0, 4);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // directed rows, then random items, then drain
  initial begin
    typedef struct {
      operands_t op;
      bit        typed;
      cplx_res_t res;
    } row_t;
    row_t rows[$];
    operands_t op;
    cplx_res_t z;
    int k;
    z = '{re: '0, im: '0, dbz: 1'b0, sat: 1'b0};
    rows = '{
      '{'{CMD_ADD, 0, 0, 0, 0}, 1, z},
      '{'{CMD_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000}, 1,
        '{32'h7fffffff, 32'h80000000, 1'b0, 1'b1}},
      '{'{CMD_SUB, 32'sh80000000, 32'sh7fffffff, 1, -1}, 1,
        '{32'h80000000, 32'h7fffffff, 1'b0, 1'b1}},
      '{'{CMD_SUB, 5, 7, 5, 7}, 1, z},
      '{'{CMD_MUL, 32'sh10000, 0, 32'sh10000, 0}, 1, '{32'h10000, 32'h0, 1'b0, 1'b0}},
      '{'{CMD_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000}, 0, z},
      '{'{CMD_MUL, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff}, 0, z},
      '{'{CMD_MUL, 1, 0, 32'sh8000, 0}, 0, z},
      '{'{CMD_MUL, -1, 0, 32'sh8000, 0}, 0, z},
      '{'{CMD_DIV, 32'sh12345, -77, 0, 0}, 1, '{32'h0, 32'h0, 1'b1, 1'b0}},
      '{'{CMD_DIV, 32'sh80000000, 32'sh7fffffff, 0, 0}, 1, '{32'h0, 32'h0, 1'b1, 1'b0}},
      '{'{CMD_DIV, 32'sh10000, 0, 32'sh10000, 0}, 0, z},
      '{'{CMD_DIV, 32'sh7fffffff, 32'sh80000000, 1, 0}, 0, z},
      '{'{CMD_DIV, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000}, 0, z},
      '{'{CMD_DIV, 1, -1, 32'sh7fffffff, 32'sh80000000}, 0, z},
      '{'{CMD_DIV, 32'sh30000, 0, 32'sh20000, 0}, 0, z},
      '{'{CMD_CONJ, 0, 32'sh80000000, 0, 0}, 1, '{32'h0, 32'h7fffffff, 1'b0, 1'b1}},
      '{'{CMD_CONJ, 32'sh80000000, 32'sh7fffffff, 3, 3}, 0, z},
      '{'{CMD_MAG, 32'sh30000, 32'sh40000, 0, 0}, 1, '{32'h50000, 32'h0, 1'b0, 1'b0}},
      '{'{CMD_MAG, 32'sh80000000, 32'sh80000000, 0, 0}, 0, z},
      '{'{CMD_MAG, -1, 0, 0, 0}, 0, z},
      '{'{CMD_SPARE6, 32'sh7fffffff, -1, 32'sh80000000, 9}, 1, z},
      '{'{CMD_SPARE7, -1, -1, -1, -1}, 1, z}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      sender_gap();
      send_item(rows[i].op, rows[i].typed ? rows[i].res : calc_result(rows[i].op));
    end
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == CALM_FROM) calm = 1'b1;
      sender_gap();
      op = pick_operands();
      send_item(op, calc_result(op));
    end
    push <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS complex_arith_unit");
    end else begin
      $display("FAIL complex_arith_unit");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("FAIL complex_arith_unit");
    $finish;
  end

endmodule
